// ----- sv/lcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Linear congruence solver package
// Shared constants for the solver and its divider.
// ----------------------------------------------------------------------------
package lcs_pkg;
   localparam int unsigned DEFAULT_WIDTH = 32;
endpackage

// ----- sv/lcs_divider.sv -----
// ----------------------------------------------------------------------------
// Shared divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcs_divider #(
   parameter int unsigned WIDTH = lcs_pkg::DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);
   import lcs_pkg::*;
   localparam int unsigned CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] q_ff, q_in, d_ff, d_in;
   logic [WIDTH:0]   r_ff, r_in, trial;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;

   assign trial = {r_ff[WIDTH-1:0], q_ff[WIDTH-1]};

   always_comb begin
      q_in = q_ff; d_in = d_ff; r_in = r_ff; cnt_in = cnt_ff;
      run_in = run_ff; done_in = 1'b0;
      if (go) begin
         q_in = dividend; d_in = divisor; r_in = '0;
         cnt_in = CW'(WIDTH); run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[WIDTH-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; d_ff <= d_in; r_ff <= r_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff[WIDTH-1:0];
endmodule

// ----- sv/linear_congruence_solver.sv -----
// ----------------------------------------------------------------------------
// Linear congruence solver
// Solves a*x == b (mod n) with extended Euclid on a shared serial divider.
// ----------------------------------------------------------------------------
// Sequence: a solvable item runs one Euclid pass (up to ~1.5*WIDTH
// divisions on the serial divider), three divisions by gcd, a second
// pass with a WIDTH-step shift-add per step and a final WIDTH-step shift-add
// modular multiply. busy stays high for the whole item.
// Throughput: one item at a time; the next start is taken once busy falls.
// Reset clears the sequencer; the result strobe cannot be stalled.
module linear_congruence_solver #(
   parameter int unsigned WIDTH = lcs_pkg::DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [WIDTH-1:0] req_coefficient,
   input  logic [WIDTH-1:0] req_target,
   input  logic [WIDTH-1:0] req_modulus,
   output logic             rsp_valid,
   output logic             rsp_solvable,
   output logic [WIDTH-1:0] rsp_solution
);
   import lcs_pkg::*;
   localparam int unsigned CW = $clog2(WIDTH + 1);

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001, S_GCD  = 11'b00000000010, S_GWAIT = 11'b00000000100,
      S_DIVB = 11'b00000001000, S_DIVN = 11'b00000010000, S_DIVA  = 11'b00000100000,
      S_EUC  = 11'b00001000000, S_EWAIT= 11'b00010000000, S_TUPD  = 11'b00100000000,
      S_MUL  = 11'b01000000000, S_DONE = 11'b10000000000
   } state_type;

   state_type        st_ff, st_in;
   logic [WIDTH-1:0] a_ff, a_in, b_ff, b_in, n_ff, n_in;
   logic [WIDTH-1:0] x_ff, x_in, y_ff, y_in;       // Euclid remainders
   logic [WIDTH-1:0] t0_ff, t0_in, t1_ff, t1_in, q_ff, q_in;
   logic [WIDTH-1:0] acc_ff, acc_in, m_ff, m_in;   // shift-add multiply
   logic [CW-1:0]    k_ff, k_in;
   logic             ok_ff, ok_in, vld_ff, vld_in;
   logic             div_go, div_done;
   logic [WIDTH-1:0] div_a, div_b, div_q, div_r;

   lcs_divider #(.WIDTH(WIDTH)) u_div (
      .clock, .reset, .go(div_go), .dividend(div_a), .divisor(div_b),
      .done(div_done), .quotient(div_q), .remainder(div_r));

   // modular add helper over n_ff (p, r < n)
   function automatic logic [WIDTH-1:0] addm(input logic [WIDTH-1:0] p,
         input logic [WIDTH-1:0] r, input logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] c;
      c = m - r;
      addm = (p >= c) ? p - c : p + r;
   endfunction

   always_comb begin
      st_in = st_ff; a_in = a_ff; b_in = b_ff; n_in = n_ff;
      x_in = x_ff; y_in = y_ff; t0_in = t0_ff; t1_in = t1_ff; q_in = q_ff;
      acc_in = acc_ff; m_in = m_ff; k_in = k_ff; ok_in = ok_ff;
      vld_in = 1'b0; div_go = 1'b0; div_a = x_ff; div_b = y_ff;
      case (st_ff)
         S_IDLE: if (start) begin
            a_in = req_coefficient; b_in = req_target; n_in = req_modulus;
            x_in = req_modulus; y_in = req_coefficient; ok_in = 1'b0;
            st_in = (req_modulus == '0) ? S_DONE : S_GCD;
         end
         S_GCD: begin
            // x holds gcd once y reaches zero
            if (y_ff == '0) begin
               div_go = 1'b1; div_a = b_ff; div_b = x_ff; st_in = S_DIVB;
            end else begin
               div_go = 1'b1; st_in = S_GWAIT;
            end
         end
         S_GWAIT: if (div_done) begin
            x_in = y_ff; y_in = div_r; st_in = S_GCD;
         end
         S_DIVB: if (div_done) begin
            if (div_r != '0) st_in = S_DONE;
            else begin
               b_in = div_q; div_go = 1'b1; div_a = n_ff; div_b = x_ff;
               st_in = S_DIVN;
            end
         end
         S_DIVN: if (div_done) begin
            n_in = div_q; div_go = 1'b1; div_a = a_ff; div_b = x_ff;
            st_in = S_DIVA;
         end
         S_DIVA: if (div_done) begin
            ok_in = 1'b1;
            // a/g mod n/g done implicitly by the Euclid steps
            x_in = n_ff; y_in = div_q; t0_in = '0;
            t1_in = (n_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
            st_in = S_EUC;
         end
         S_EUC: begin
            if (y_ff == '0) begin
               // t0 is inverse; now multiply b*t0 mod n
               acc_in = '0; m_in = t0_ff; k_in = CW'(WIDTH);
               q_in = b_ff; st_in = S_MUL;
            end else begin
               div_go = 1'b1; st_in = S_EWAIT;
            end
         end
         S_EWAIT: if (div_done) begin
            x_in = y_ff; y_in = div_r;
            // q*t1 mod n: q reduced through multiply loop
            q_in = div_q; acc_in = '0; m_in = t1_ff; k_in = CW'(WIDTH);
            st_in = S_TUPD;
         end
         S_TUPD: begin
            // acc = acc*2 + (q msb ? m) mod n, msb first
            acc_in = addm(acc_ff, acc_ff, n_ff);
            if (q_ff[WIDTH-1]) acc_in = addm(acc_in, m_ff, n_ff);
            q_in = {q_ff[WIDTH-2:0], 1'b0};
            k_in = k_ff - 1'b1;
            if (k_ff == CW'(1)) begin
               t0_in = t1_ff;
               t1_in = (t0_ff >= acc_in) ? t0_ff - acc_in : n_ff - (acc_in - t0_ff);
               st_in = S_EUC;
            end
         end
         S_MUL: begin
            // shift-add, msb first; the multiplier needs no reduction
            acc_in = addm(acc_ff, acc_ff, n_ff);
            if (q_ff[WIDTH-1]) acc_in = addm(acc_in, m_ff, n_ff);
            q_in = {q_ff[WIDTH-2:0], 1'b0};
            k_in = k_ff - 1'b1;
            if (k_ff == CW'(1)) st_in = S_DONE;
         end
         S_DONE: begin
            vld_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in;
      end
      a_ff <= a_in; b_ff <= b_in; n_ff <= n_in; x_ff <= x_in; y_ff <= y_in;
      t0_ff <= t0_in; t1_ff <= t1_in; ok_ff <= ok_in; m_ff <= m_in;
      q_ff <= q_in; acc_ff <= acc_in; k_ff <= k_in;
   end

   assign busy         = (st_ff != S_IDLE);
   assign rsp_valid    = vld_ff;
   assign rsp_solvable = ok_ff;
   assign rsp_solution = ok_ff ? acc_ff : '0;

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
   a_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_solvable |-> rsp_solution < n_ff || n_ff == '0)
      else $error("solution out of range");
endmodule
